/* design/ccp_pkg.sv */
// Shared types and constants of the chain-code curve plotter.
package ccp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2
  } axis_t;

  typedef struct packed {
    logic below;
    logic above;
  } region_t;

  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 13;
  localparam int unsigned PIXEL_BITS    = 12;
  localparam int unsigned STEP_BITS     = 15;

  localparam logic [CFG_IDX_BITS-1:0] REG_RASTER_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RASTER_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_BITS-1:0] RASTER_MAX   = 13'd4096;
  localparam logic [CFG_DATA_BITS-1:0] RASTER_RESET = 13'd1024;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_SEGMENT = 1'b1;

endpackage

/* design/ccp_in_if.sv */
// Input channel of the curve plotter: start and segment items.
interface ccp_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [4:0]  delta_x;
  logic signed [4:0]  delta_y;
  logic [15:0]        step_bits;

  modport source (
    output valid, req_type, start_x, start_y, delta_x, delta_y, step_bits,
    input  ready
  );
  modport sink (
    input  valid, req_type, start_x, start_y, delta_x, delta_y, step_bits,
    output ready
  );
endinterface

/* design/ccp_out_if.sv */
// Result channel of the curve plotter: one pixel per transfer.
interface ccp_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic        last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, last_pixel,
    output ready
  );
endinterface

/* design/ccp_region.sv */
// Classifies one coordinate as below zero, inside, or at or beyond a raster limit.
module ccp_region #(
  parameter int unsigned XW = 17
) (
  input  logic signed [XW-1:0] coord,
  input  logic [12:0]          limit,
  output ccp_pkg::region_t     region
);
  logic signed [XW-1:0] limit_s;

  assign limit_s       = XW'(limit);
  assign region.below  = coord[XW-1];
  assign region.above  = coord >= limit_s;
endmodule

/* design/chain_code_curve_plotter_top.sv */
// Top level of the chain-code curve plotter.
//
// Items arrive on in_ch. A start item places the pen and is done in the
// cycle of its transfer. A segment item moves the pen and, unless it is
// zero, pen-up or a non-diagonal segment wholly outside the raster, walks
// its steps; the pixels that fall inside the raster leave on out_ch, the
// final one of each item marked with last_pixel. A segment is classified
// in ST_DECIDE, walks its steps (up to MAX_STEPS) in ST_WALK and then
// releases the held pixel in ST_FLUSH.
// Unless stalled, the step walker moves the pen position by one pixel per
// cycle and takes one step bit per cycle from a shift register; that loop
// sets the rate. A new item is taken only when the previous one has
// finished walking, while its final pixel may still sit in the output
// register. When out_ch stalls, the walker holds as soon as it finds a
// pixel with both the held pixel and the output register full.
// Reset gives the pen the origin, no previous major axis and raster limits
// of 1024 by 1024. The cfg port writes the raster width and height;
// values above 4096 act as 4096.
module chain_code_curve_plotter_top #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned MAX_STEPS  = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ccp_in_if.sink                            in_ch,
  ccp_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [ccp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ccp_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  localparam int unsigned XW       = (COORD_BITS + 1 > 14) ? COORD_BITS + 1 : 14;
  localparam int unsigned CNT_BITS = $clog2(MAX_STEPS + 1);
  localparam int unsigned PB       = ccp_pkg::PIXEL_BITS;
  localparam int unsigned SB       = ccp_pkg::STEP_BITS;

  ccp_pkg::state_t                    state_r, state_nxt;
  logic [ccp_pkg::CFG_DATA_BITS-1:0]  raster_w_r, raster_h_r, cfg_clamped;
  logic [COORD_BITS-1:0]              pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  ccp_pkg::axis_t                     axis_r, axis_nxt;
  logic                               lsx_r, lsx_nxt;
  logic signed [4:0]                  dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SB-1:0]                      steps_r, steps_nxt;
  logic                               pen_up_r, pen_up_nxt;
  logic                               diag_r, diag_nxt, xmaj_r, xmaj_nxt;
  logic [CNT_BITS-1:0]                cnt_r, cnt_nxt;
  logic signed [XW-1:0]               wx_r, wx_nxt, wy_r, wy_nxt;
  logic                               pend_v_r, pend_v_nxt;
  logic [PB-1:0]                      pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic                               out_v_r, out_v_nxt;
  logic [PB-1:0]                      out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                               out_last_r, out_last_nxt;

  logic signed [5:0]     dxe, dye;
  logic [5:0]            ax, ay, sum_a, walk_len;
  logic                  seg_zero, seg_diag, seg_xmaj, outside, inside0, axis_chg;
  ccp_pkg::axis_t        code;
  logic [COORD_BITS-1:0] npx, npy;
  logic signed [XW-1:0]  npx_s, npy_s, wx_step, wy_step;
  ccp_pkg::region_t      rx0, ry0, rnx, rny, rwx, rwy;
  logic                  isx, hit, slot_free, walk_en, flush_push, in_xfer;

  assign dxe     = 6'(dx_r);
  assign dye     = 6'(dy_r);
  assign ax      = dxe[5] ? 6'(-dxe) : 6'(dxe);
  assign ay      = dye[5] ? 6'(-dye) : 6'(dye);
  assign sum_a   = ax + ay;
  assign seg_zero = (sum_a == 6'd0);
  assign seg_diag = (ax == ay);
  assign seg_xmaj = (ax > ay);
  assign code     = seg_xmaj ? ccp_pkg::AXIS_X : ccp_pkg::AXIS_Y;
  assign npx      = pen_x_r + COORD_BITS'(dx_r);
  assign npy      = pen_y_r + COORD_BITS'(dy_r);
  assign npx_s    = XW'($signed(npx));
  assign npy_s    = XW'($signed(npy));

  ccp_region #(.XW(XW)) u_rx0 (.coord(wx_r),    .limit(raster_w_r), .region(rx0));
  ccp_region #(.XW(XW)) u_ry0 (.coord(wy_r),    .limit(raster_h_r), .region(ry0));
  ccp_region #(.XW(XW)) u_rnx (.coord(npx_s),   .limit(raster_w_r), .region(rnx));
  ccp_region #(.XW(XW)) u_rny (.coord(npy_s),   .limit(raster_h_r), .region(rny));
  ccp_region #(.XW(XW)) u_rwx (.coord(wx_step), .limit(raster_w_r), .region(rwx));
  ccp_region #(.XW(XW)) u_rwy (.coord(wy_step), .limit(raster_h_r), .region(rwy));

  assign inside0  = (rx0 == '0) && (ry0 == '0);
  assign outside  = !inside0 && (((rx0 != '0) && (rx0 == rnx)) ||
                                 ((ry0 != '0) && (ry0 == rny)));
  assign axis_chg = ((axis_r == ccp_pkg::AXIS_NONE) ||
                     (lsx_r != (axis_r == ccp_pkg::AXIS_X))) && (axis_r != code);
  assign walk_len = seg_diag ? ((ax > 6'(MAX_STEPS)) ? 6'(MAX_STEPS) : ax)
                             : ((sum_a > 6'(MAX_STEPS)) ? 6'(MAX_STEPS) : sum_a);

  assign isx     = diag_r | steps_r[SB-1];
  assign wx_step = (diag_r || isx) ? (dx_r[4] ? wx_r - XW'(1) : wx_r + XW'(1)) : wx_r;
  assign wy_step = (diag_r || !isx) ? (dy_r[4] ? wy_r - XW'(1) : wy_r + XW'(1)) : wy_r;
  assign hit     = (diag_r || (isx == xmaj_r)) && (rwx == '0) && (rwy == '0);
  assign slot_free = !out_v_r || out_ch.ready;

  assign cfg_clamped = (cfg_wdata > ccp_pkg::RASTER_MAX) ? ccp_pkg::RASTER_MAX : cfg_wdata;

  // Output decode of the sequencer.
  always_comb begin
    in_ch.ready = 1'b0;
    walk_en     = 1'b0;
    flush_push  = 1'b0;
    case (state_r)
      ccp_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ccp_pkg::ST_WALK: begin
        walk_en = !(hit && pend_v_r && !slot_free);
      end
      ccp_pkg::ST_FLUSH: begin
        flush_push = pend_v_r && slot_free;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  assign in_xfer = in_ch.valid && in_ch.ready;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccp_pkg::ST_IDLE: begin
        if (in_xfer && (in_ch.req_type == ccp_pkg::REQ_SEGMENT)) begin
          state_nxt = ccp_pkg::ST_DECIDE;
        end
      end
      ccp_pkg::ST_DECIDE: begin
        if (seg_zero) begin
          state_nxt = ccp_pkg::ST_IDLE;
        end else if (pen_up_r || (!seg_diag && outside)) begin
          state_nxt = ccp_pkg::ST_FLUSH;
        end else begin
          state_nxt = ccp_pkg::ST_WALK;
        end
      end
      ccp_pkg::ST_WALK: begin
        if (walk_en && (cnt_r == CNT_BITS'(1))) begin
          state_nxt = ccp_pkg::ST_FLUSH;
        end
      end
      ccp_pkg::ST_FLUSH: begin
        if (!pend_v_r || slot_free) begin
          state_nxt = ccp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ccp_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    pen_x_nxt    = pen_x_r;
    pen_y_nxt    = pen_y_r;
    axis_nxt     = axis_r;
    lsx_nxt      = lsx_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    steps_nxt    = steps_r;
    pen_up_nxt   = pen_up_r;
    diag_nxt     = diag_r;
    xmaj_nxt     = xmaj_r;
    cnt_nxt      = cnt_r;
    wx_nxt       = wx_r;
    wy_nxt       = wy_r;
    pend_v_nxt   = pend_v_r;
    pend_x_nxt   = pend_x_r;
    pend_y_nxt   = pend_y_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_last_nxt = out_last_r;

    if (state_r == ccp_pkg::ST_IDLE && in_xfer) begin
      if (in_ch.req_type == ccp_pkg::REQ_START) begin
        pen_x_nxt = COORD_BITS'(in_ch.start_x);
        pen_y_nxt = COORD_BITS'(in_ch.start_y);
        axis_nxt  = ccp_pkg::AXIS_NONE;
        lsx_nxt   = 1'b0;
      end else begin
        dx_nxt     = in_ch.delta_x;
        dy_nxt     = in_ch.delta_y;
        steps_nxt  = in_ch.step_bits[SB-1:0];
        pen_up_nxt = in_ch.step_bits[SB];
        wx_nxt     = XW'($signed(pen_x_r));
        wy_nxt     = XW'($signed(pen_y_r));
      end
    end

    if (state_r == ccp_pkg::ST_DECIDE) begin
      pen_x_nxt = npx;
      pen_y_nxt = npy;
      diag_nxt  = seg_diag;
      xmaj_nxt  = seg_xmaj;
      cnt_nxt   = CNT_BITS'(walk_len);
      if (!seg_zero) begin
        if (seg_diag) begin
          lsx_nxt = pen_up_r;
        end else begin
          axis_nxt = code;
          if (axis_chg && inside0) begin
            pend_v_nxt = 1'b1;
            pend_x_nxt = wx_r[PB-1:0];
            pend_y_nxt = wy_r[PB-1:0];
          end
          if (pen_up_r) begin
            lsx_nxt = 1'b1;
          end else if (outside) begin
            lsx_nxt = 1'b0;
          end
        end
      end
    end

    if (walk_en) begin
      wx_nxt    = wx_step;
      wy_nxt    = wy_step;
      steps_nxt = {steps_r[SB-2:0], 1'b0};
      cnt_nxt   = cnt_r - CNT_BITS'(1);
      if (!diag_r) begin
        lsx_nxt = isx;
      end
      if (hit) begin
        if (pend_v_r) begin
          out_v_nxt    = 1'b1;
          out_x_nxt    = pend_x_r;
          out_y_nxt    = pend_y_r;
          out_last_nxt = 1'b0;
        end
        pend_v_nxt = 1'b1;
        pend_x_nxt = wx_step[PB-1:0];
        pend_y_nxt = wy_step[PB-1:0];
      end
    end

    if (flush_push) begin
      out_v_nxt    = 1'b1;
      out_x_nxt    = pend_x_r;
      out_y_nxt    = pend_y_r;
      out_last_nxt = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ccp_pkg::ST_IDLE;
      raster_w_r <= ccp_pkg::RASTER_RESET;
      raster_h_r <= ccp_pkg::RASTER_RESET;
      pen_x_r    <= '0;
      pen_y_r    <= '0;
      axis_r     <= ccp_pkg::AXIS_NONE;
      lsx_r      <= 1'b0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      pen_x_r  <= pen_x_nxt;
      pen_y_r  <= pen_y_nxt;
      axis_r   <= axis_nxt;
      lsx_r    <= lsx_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_we && (cfg_index == ccp_pkg::REG_RASTER_WIDTH)) begin
        raster_w_r <= cfg_clamped;
      end
      if (cfg_we && (cfg_index == ccp_pkg::REG_RASTER_HEIGHT)) begin
        raster_h_r <= cfg_clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    steps_r    <= steps_nxt;
    pen_up_r   <= pen_up_nxt;
    diag_r     <= diag_nxt;
    xmaj_r     <= xmaj_nxt;
    wx_r       <= wx_nxt;
    wy_r       <= wy_nxt;
    pend_x_r   <= pend_x_nxt;
    pend_y_r   <= pend_y_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.pixel_x    = out_x_r;
  assign out_ch.pixel_y    = out_y_r;
  assign out_ch.last_pixel = out_last_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccp_pkg::ST_IDLE) |-> !pend_v_r)
    else $error("pixel still held while the plotter is idle");

  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccp_pkg::ST_WALK) |-> (cnt_r != '0))
    else $error("walker running with no steps left");

  a_pixel_in_raster: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((13'(out_x_r) < raster_w_r) && (13'(out_y_r) < raster_h_r)))
    else $error("emitted pixel lies outside the raster");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ccp_pkg::ST_FLUSH) && !pend_v_r) |=> (state_r == ccp_pkg::ST_IDLE))
    else $error("flush with nothing held did not return to idle");

endmodule
